FILE: hw/rtl/lgt_pkg.sv
`timescale 1ns / 1ps
package lgt_pkg;

  localparam int DATA_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int MAX_POINTS_DEF  = 256;
  localparam logic [DATA_W-1:0] LEN_RESET = 32'd65536;

  // status codes of a result
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_LOAD,
    S_SCAN,
    S_DONE
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              ins;
    logic              load;
    logic              shift;
    logic [DATA_W-1:0] point;
    logic [DATA_W-1:0] len;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/lgt_cell.sv
`timescale 1ns / 1ps
module lgt_cell
  import lgt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic              prev_valid,
  input  logic              prev_less,
  input  logic [DATA_W-1:0] prev_pos,
  input  logic              next_valid,
  input  logic [DATA_W-1:0] next_pos,
  input  logic [DATA_W-1:0] next_scan,
  output logic [DATA_W-1:0] pos,
  output logic              valid,
  output logic              less,
  output logic              dup,
  output logic [DATA_W-1:0] scan
);

  logic [DATA_W-1:0] pos_next;
  logic [DATA_W-1:0] right;
  logic [DATA_W-1:0] gap;

  assign less = valid && (pos < ctl.point);
  assign dup  = valid && (pos == ctl.point);

  // sorted insert: keep if smaller, take the point at the boundary, else shift up
  always_comb begin
    if (less) begin
      pos_next = pos;
    end else if (prev_less) begin
      pos_next = ctl.point;
    end else begin
      pos_next = prev_pos;
    end
  end

  // gap to the right neighbor, or to the segment end for the last point
  assign right = next_valid ? next_pos : ctl.len;
  assign gap   = (valid && (right > pos)) ? (right - pos) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid | prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      pos <= pos_next;
    end
    if (ctl.load) begin
      scan <= gap;
    end else if (ctl.shift) begin
      scan <= next_scan;
    end
  end

endmodule

FILE: hw/rtl/lgt_ctrl.sv
`timescale 1ns / 1ps
module lgt_ctrl
  import lgt_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DATA_W-1:0]   in_point,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_gap,
  output logic [STATUS_W-1:0] out_status,
  input  logic                cfg_valid,
  input  logic [DATA_W-1:0]   cfg_data,
  input  logic                dup_any,
  input  logic [DATA_W-1:0]   head_pos,
  input  logic [DATA_W-1:0]   head_scan,
  output cell_ctl_t           ctl
);

  state_t                state;
  state_t                state_next;
  logic [DATA_W-1:0]     line_len;
  logic [DATA_W-1:0]     point;
  logic [CW-1:0]         count;
  logic [CW-1:0]         scan_cnt;
  logic [DATA_W-1:0]     best;
  logic [STATUS_W-1:0]   status;
  logic                  range_bad;
  logic                  full;
  logic                  ok;
  logic                  out_free;

  assign range_bad = (point == '0) || (point >= line_len);
  assign full      = (count == CW'(MAX_POINTS));
  assign ok        = !range_bad && !dup_any && !full;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_INSERT;
      S_INSERT: state_next = S_LOAD;
      S_LOAD:   state_next = (count == '0) ? S_DONE : S_SCAN;
      S_SCAN:   if (scan_cnt == CW'(1)) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ctl.ins   = 1'b0;
    ctl.load  = 1'b0;
    ctl.shift = 1'b0;
    ctl.point = point;
    ctl.len   = line_len;
    unique case (state)
      S_IDLE:   in_ready  = 1'b1;
      S_INSERT: ctl.ins   = ok;
      S_LOAD:   ctl.load  = 1'b1;
      S_SCAN:   ctl.shift = 1'b1;
      S_DONE:   ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      line_len  <= LEN_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        line_len <= cfg_data;
      end
      if (state == S_INSERT && ok) begin
        count <= count + CW'(1);
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      point <= in_point;
    end
    if (state == S_INSERT) begin
      if (range_bad || dup_any) begin
        status <= ST_REJECTED;
      end else if (full) begin
        status <= ST_FULL;
      end else begin
        status <= ST_INSERTED;
      end
    end
    if (state == S_LOAD) begin
      best     <= (count == '0) ? line_len : head_pos;
      scan_cnt <= count;
    end
    if (state == S_SCAN) begin
      if (head_scan > best) begin
        best <= head_scan;
      end
      scan_cnt <= scan_cnt - CW'(1);
    end
    if (state == S_DONE && out_free) begin
      out_gap    <= best;
      out_status <= status;
    end
  end

endmodule

FILE: hw/rtl/largest_gap_tracker.sv
`timescale 1ns / 1ps
// channel   dir  fields (lsb first)                handshake
// s_axis    in   tdata: position[31:0]             tvalid/tready
// m_axis    out  tdata: longest_gap[31:0]          tvalid/tready
//                tuser: status[1:0]
// cfg       in   data: line_length[31:0]           valid/ready, ready always high
//
// m_axis_tvalid rises once the item has passed the INSERT, LOAD, SCAN and DONE states,
// with SCAN skipped for an empty store; the next item is only taken back in IDLE, after
// DONE, so a new item is not taken while the last one is still in the store update
// the gap scan shifts every cell's gap one place toward the head of the cell chain per
// cycle into a single running-max comparator
// rst is synchronous: the store empties and line_length returns to 65536
// the result sits in an output register, so the next item is taken while it waits;
// a stalled m_axis only holds the sequencer once a second result is ready
module largest_gap_tracker
  import lgt_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // position[31:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // longest_gap[31:0]
  output logic [1:0]          m_axis_tuser,   // status[1:0]
  // line_length
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] pos   [MAX_POINTS];
  logic [DATA_W-1:0] scan  [MAX_POINTS];
  logic              valid [MAX_POINTS];
  logic              less  [MAX_POINTS];
  logic [MAX_POINTS-1:0] dup;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  lgt_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_point   (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_gap    (m_axis_tdata),
    .out_status (m_axis_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .dup_any    (|dup),
    .head_pos   (pos[0]),
    .head_scan  (scan[0]),
    .ctl        (ctl)
  );

  // cell 0 holds the smallest point; the chain end sees no neighbor
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    logic              p_valid;
    logic              p_less;
    logic [DATA_W-1:0] p_pos;
    logic              n_valid;
    logic [DATA_W-1:0] n_pos;
    logic [DATA_W-1:0] n_scan;

    if (i == 0) begin : g_head
      assign p_valid = 1'b1;
      assign p_less  = 1'b1;
      assign p_pos   = '0;
    end else begin : g_body
      assign p_valid = valid[i-1];
      assign p_less  = less[i-1];
      assign p_pos   = pos[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_pos   = '0;
      assign n_scan  = '0;
    end else begin : g_link
      assign n_valid = valid[i+1];
      assign n_pos   = pos[i+1];
      assign n_scan  = scan[i+1];
    end

    lgt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (p_valid),
      .prev_less  (p_less),
      .prev_pos   (p_pos),
      .next_valid (n_valid),
      .next_pos   (n_pos),
      .next_scan  (n_scan),
      .pos        (pos[i]),
      .valid      (valid[i]),
      .less       (less[i]),
      .dup        (dup[i]),
      .scan       (scan[i])
    );
  end

endmodule
